// ===== rtl/rna_pkg.sv =====
`timescale 1ns / 1ps
package rna_pkg;
  localparam int WORD_W_DEF = 32;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
    MODE_RED = 4'd4, MODE_MIX = 4'd5, MODE_LT = 4'd6, MODE_GT = 4'd7,
    MODE_EQ = 4'd8
  } mode_t;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_MUL = 2'd0, OP_DIV = 2'd1
  } op_t;
endpackage

// ===== rtl/rational_number_alu_unit.sv =====
`timescale 1ns / 1ps
// Rational arithmetic unit on fractions in mixed form.
// Input channel in_*: one word per item carrying mode and both operands,
// with the reduce flag in in_tuser. Output channel out_*: one result word
// per item, with the compare outcome in out_tuser.
// Each item is worked by a sequencer driving one shared bit-serial
// multiply/divide unit, and gcds run their Euclid steps on the divider.
// An undefined mode or an add/sub with a zero denominator goes straight
// to the output step without any unit operation. Ordinary operands
// need some 10 to 20 unit operations; with the longest Euclid runs an
// add needs about 150 operations. One item is worked at a time:
// in_tready is high only while the sequencer is idle.
// A finished result moves to the output register. While the receiver
// stalls, the next word is accepted and worked, and its result holds until
// the output register is free. Reset (rst_n low, synchronous) drops any
// item in flight and empties the output register.
module rational_number_alu_unit
  import rna_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_W_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // mode[3:0], a_whole, a_num, a_den, b_whole, b_num, b_den, pad
  input  logic [199:0]  in_tdata,
  // reduce
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // res_whole, res_num, res_den
  output logic [95:0]   out_tdata,
  // flag
  output logic          out_tuser
);
  localparam int W = WORD_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE, S_NA_M, S_NA_G, S_NB_M, S_NB_G,
    S_G_ST, S_G_WT, S_DV_ST, S_DV_WT,
    S_OP, S_AS1, S_AS2, S_AS3, S_AS4,
    S_MD1, S_MD2, S_MD3,
    S_MX, S_CM1, S_CM2, S_CM3, S_OUT
  } state_t;

  state_t        st_r, ret_r, gret_r;
  logic [3:0]    mode_r;
  logic          red_r;
  logic [W-1:0]  am_r, ap_r, aq_r, bm_r, bp_r, bq_r;
  logic [W-1:0]  gu_r, gv_r, g_r;
  logic [W-1:0]  x_r, y_r, t_r;
  logic [2*W-1:0] px_r;
  logic [1:0]    sel_r;
  logic [2:0]    dstep_r;
  logic          ovalid_r, flag_r;
  logic [31:0]   ow_r, on_r, od_r;
  logic [95:0]   odata_r;
  logic          ouser_r;

  logic          u_start;
  op_t           u_op;
  logic [W-1:0]  u_a, u_b;
  logic          u_done;
  logic [2*W-1:0] u_prod;
  logic [W-1:0]  u_quot, u_rem;

  rna_unit #(.W(W)) u_unit (
    .clk(clk), .rst_n(rst_n), .start(u_start), .op(u_op), .opa(u_a), .opb(u_b),
    .done(u_done), .prod(u_prod), .quot(u_quot), .rem(u_rem)
  );

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction
  function automatic logic [W-1:0] sx(input logic [31:0] v);
    return W'($signed(v));
  endfunction
  function automatic logic [31:0] to32(input logic [W-1:0] v);
    return 32'($signed(v));
  endfunction

  // operand the unit works on, picked by the sequencer; a toggle of
  // ust_r marks a start for one cycle
  logic          ust_r, ustq_r;
  op_t           uop_r;
  logic [W-1:0]  ua_r, ub_r;
  assign u_start = ust_r ^ ustq_r;
  assign u_op    = uop_r;
  assign u_a     = ua_r;
  assign u_b     = ub_r;

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  logic xn, yn;
  always_comb begin
    xn = (px_r != '0) && (ap_r[W-1] != aq_r[W-1]);
    yn = (u_prod != '0) && (bp_r[W-1] != bq_r[W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ovalid_r <= 1'b0;
      ust_r    <= 1'b0;
      ustq_r   <= 1'b0;
    end else begin
      ustq_r <= ust_r;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          mode_r <= in_tdata[3:0];
          am_r <= sx(in_tdata[35:4]);   ap_r <= sx(in_tdata[67:36]);
          aq_r <= sx(in_tdata[99:68]);  bm_r <= sx(in_tdata[131:100]);
          bp_r <= sx(in_tdata[163:132]); bq_r <= sx(in_tdata[195:164]);
          red_r <= in_tuser;
          ow_r <= '0; on_r <= '0; od_r <= '0; flag_r <= 1'b0;
          st_r <= S_OP;
        end
        // dispatch by mode
        S_OP: begin
          priority if ((mode_r == MODE_ADD || mode_r == MODE_SUB) &&
                       (aq_r == '0 || bq_r == '0)) begin
            ow_r <= to32(am_r); on_r <= to32(ap_r); od_r <= to32(aq_r);
            st_r <= S_OUT;
          end else if (mode_r <= 4'(MODE_EQ)) begin
            sel_r <= 2'd0;
            st_r  <= S_NA_M;
          end else st_r <= S_OUT;
        end
        // fold whole part: p = m*q + p
        S_NA_M: begin
          if (sel_r[0] ? bm_r == '0 : am_r == '0) st_r <= S_NA_G;
          else begin
            ust_r <= ~ust_r; uop_r <= OP_MUL;
            ua_r <= sel_r[0] ? bm_r : am_r; ub_r <= sel_r[0] ? bq_r : aq_r;
            st_r <= S_NB_M;
          end
        end
        S_NB_M: if (u_done) begin
          if (sel_r[0]) begin bp_r <= u_prod[W-1:0] + bp_r; bm_r <= '0; end
          else begin ap_r <= u_prod[W-1:0] + ap_r; am_r <= '0; end
          st_r <= S_NA_G;
        end
        // reduce by gcd
        S_NA_G: begin
          gu_r <= mag(sel_r[0] ? bp_r : ap_r);
          gv_r <= mag(sel_r[0] ? bq_r : aq_r);
          gret_r <= S_NB_G;
          st_r <= S_G_ST;
        end
        S_NB_G: begin
          if (g_r > W'(1) && !sel_r[1]) begin
            x_r <= sel_r[0] ? bp_r : ap_r; y_r <= sel_r[0] ? bq_r : aq_r;
            dstep_r <= 3'd0; ret_r <= S_NB_G; sel_r[1] <= 1'b1;
            st_r <= S_DV_ST;
          end else begin
            // write back the reduced pair, then go on to b or to the op
            if (sel_r[1]) begin
              if (sel_r[0]) begin bp_r <= x_r; bq_r <= y_r; end
              else begin ap_r <= x_r; aq_r <= y_r; end
            end
            sel_r <= 2'b01;
            st_r <= sel_r[0] ? S_AS1 : S_NA_M;
          end
        end
        // euclid: while v, (u,v) = (v, u % v)
        S_G_ST: begin
          if (gv_r == '0) begin g_r <= gu_r; st_r <= gret_r; end
          else begin
            ust_r <= ~ust_r; uop_r <= OP_DIV; ua_r <= gu_r; ub_r <= gv_r;
            st_r <= S_G_WT;
          end
        end
        S_G_WT: if (u_done) begin
          gu_r <= gv_r; gv_r <= u_rem; st_r <= S_G_ST;
        end
        // divide x then y by g with sign
        S_DV_ST: begin
          ust_r <= ~ust_r; uop_r <= OP_DIV; ub_r <= g_r;
          ua_r <= mag(dstep_r[0] ? y_r : x_r);
          st_r <= S_DV_WT;
        end
        S_DV_WT: if (u_done) begin
          if (dstep_r[0]) begin
            y_r <= y_r[W-1] ? W'(-u_quot) : u_quot; st_r <= ret_r;
          end else begin
            x_r <= x_r[W-1] ? W'(-u_quot) : u_quot;
            dstep_r <= 3'd1; st_r <= S_DV_ST;
          end
        end
        // both normalized
        S_AS1: begin
          unique case (mode_r)
            MODE_ADD, MODE_SUB: begin
              gu_r <= mag(aq_r); gv_r <= mag(bq_r); gret_r <= S_AS2;
              st_r <= S_G_ST;
            end
            MODE_MUL, MODE_DIV: begin
              if (mode_r == MODE_DIV) begin bp_r <= bq_r; bq_r <= bp_r; end
              st_r <= S_MD1;
            end
            MODE_RED: begin
              on_r <= to32(ap_r); od_r <= to32(aq_r); st_r <= S_OUT;
            end
            MODE_MIX: st_r <= S_MX;
            default: st_r <= S_CM1;
          endcase
        end
        // fa = |bq|/g into x, fb = |aq|/g into y
        S_AS2: begin
          ust_r <= ~ust_r; uop_r <= OP_DIV; ua_r <= mag(bq_r); ub_r <= g_r;
          dstep_r <= 3'd0; st_r <= S_AS3;
        end
        S_AS3: if (u_done) begin
          unique case (dstep_r)
            3'd0: begin
              x_r <= u_quot; ust_r <= ~ust_r; ua_r <= mag(aq_r); ub_r <= g_r;
              uop_r <= OP_DIV;
            end
            3'd1: begin
              y_r <= u_quot; ust_r <= ~ust_r; uop_r <= OP_MUL;
              ua_r <= ap_r; ub_r <= x_r;
            end
            3'd2: begin
              t_r <= aq_r[W-1] ? W'(-u_prod[W-1:0]) : u_prod[W-1:0];
              ust_r <= ~ust_r; uop_r <= OP_MUL; ua_r <= bp_r; ub_r <= y_r;
            end
            3'd3: begin
              t_r <= (mode_r == MODE_SUB) ?
                t_r - (bq_r[W-1] ? W'(-u_prod[W-1:0]) : u_prod[W-1:0]) :
                t_r + (bq_r[W-1] ? W'(-u_prod[W-1:0]) : u_prod[W-1:0]);
              ust_r <= ~ust_r; uop_r <= OP_MUL; ua_r <= mag(aq_r); ub_r <= x_r;
            end
            default: begin
              on_r <= to32(t_r); od_r <= to32(u_prod[W-1:0]); st_r <= S_OUT;
            end
          endcase
          dstep_r <= dstep_r + 3'd1;
        end
        // product terms
        S_MD1: begin
          ust_r <= ~ust_r; uop_r <= OP_MUL; ua_r <= ap_r; ub_r <= bp_r;
          st_r <= S_MD2;
        end
        S_MD2: if (u_done) begin
          x_r <= u_prod[W-1:0];
          ust_r <= ~ust_r; uop_r <= OP_MUL; ua_r <= aq_r; ub_r <= bq_r;
          st_r <= S_MD3;
        end
        S_MD3: begin
          if (u_done) begin
            y_r <= u_prod[W-1:0];
            if (red_r) begin
              gu_r <= mag(x_r); gv_r <= mag(u_prod[W-1:0]);
              gret_r <= S_AS4; st_r <= S_G_ST;
            end else begin
              on_r <= to32(x_r); od_r <= to32(u_prod[W-1:0]); st_r <= S_OUT;
            end
          end
        end
        // reduce the product once by its gcd
        S_AS4: begin
          if (g_r > W'(1) && !sel_r[1]) begin
            dstep_r <= 3'd0; ret_r <= S_AS4; sel_r[1] <= 1'b1; st_r <= S_DV_ST;
          end else begin
            on_r <= to32(x_r); od_r <= to32(y_r); st_r <= S_OUT;
          end
        end
        // mixed form
        S_MX: begin
          if (!($signed(ap_r) < $signed(aq_r)) && aq_r != '0) begin
            if (!sel_r[1]) begin
              ust_r <= ~ust_r; uop_r <= OP_DIV; ua_r <= mag(ap_r);
              ub_r <= mag(aq_r); sel_r[1] <= 1'b1;
            end else if (u_done) begin
              ow_r <= to32((ap_r[W-1] != aq_r[W-1]) ? W'(-u_quot) : u_quot);
              on_r <= to32(ap_r[W-1] ? W'(-u_rem) : u_rem);
              od_r <= to32(aq_r);
              st_r <= S_OUT;
            end
          end else begin
            on_r <= to32(ap_r); od_r <= to32(aq_r); st_r <= S_OUT;
          end
        end
        // cross products of magnitudes
        S_CM1: begin
          ust_r <= ~ust_r; uop_r <= OP_MUL; ua_r <= mag(ap_r); ub_r <= mag(bq_r);
          st_r <= S_CM2;
        end
        S_CM2: if (u_done) begin
          px_r <= u_prod;
          ust_r <= ~ust_r; uop_r <= OP_MUL; ua_r <= mag(bp_r); ub_r <= mag(aq_r);
          st_r <= S_CM3;
        end
        S_CM3: if (u_done) begin
          unique case (mode_r)
            MODE_LT: flag_r <= (xn != yn) ? xn :
                               (xn ? (px_r > u_prod) : (px_r < u_prod));
            MODE_GT: flag_r <= (xn != yn) ? yn :
                               (xn ? (px_r < u_prod) : (px_r > u_prod));
            default: flag_r <= (xn == yn) && (px_r == u_prod);
          endcase
          st_r <= S_OUT;
        end
        // hand the result to the output register once it is free
        S_OUT: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          odata_r <= {od_r, on_r, ow_r};
          ouser_r <= flag_r;
          dstep_r <= 3'd0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/rna_unit.sv =====
`timescale 1ns / 1ps
// Shared unsigned unit: shift-add multiply (2W product) or restoring divide,
// one bit per cycle.
module rna_unit
  import rna_pkg::*;
#(
  parameter int W = WORD_W_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  op_t            op,
  input  logic [W-1:0]   opa,
  input  logic [W-1:0]   opb,
  output logic           done,
  output logic [2*W-1:0] prod,
  output logic [W-1:0]   quot,
  output logic [W-1:0]   rem
);
  localparam int CW = $clog2(W + 1);

  logic           busy_r, busy_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  op_t            op_r, op_nxt;
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic           done_r, done_nxt;
  logic [W:0]     trial;
  logic [W:0]     shrem;

  assign shrem = {acc_r[W-1:0], a_r[W-1]};
  assign trial = shrem - {1'b0, b_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      op_nxt   = op;
      acc_nxt  = '0;
      a_nxt    = opa;
      b_nxt    = opb;
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          // add then shift right, multiplier bits leave from the bottom
          acc_nxt = {(W+1)'({1'b0, acc_r[2*W-1:W]} + (a_r[0] ? {1'b0, b_r} : '0)),
                     acc_r[W-1:1]};
          a_nxt   = a_r >> 1;
        end
        OP_DIV: begin
          // shift in next dividend bit, subtract when it fits
          if (!trial[W]) acc_nxt[W-1:0] = trial[W-1:0];
          else acc_nxt[W-1:0] = shrem[W-1:0];
          a_nxt = {a_r[W-2:0], ~trial[W]};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
  assign quot = a_r;
  assign rem  = acc_r[W-1:0];
endmodule
